// File: rtl/core/sliding_window_per_key_limiter_assert.svh
// assertion macros for the sliding window per-key limiter
// no dependencies; included by the top level
`ifndef SLIDING_WINDOW_PER_KEY_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_PER_KEY_LIMITER_ASSERT_SVH

// same-cycle implication
`define SWPKL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swpkl assertion failed");

// next-cycle implication
`define SWPKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swpkl assertion failed");

`endif

// File: rtl/core/swpkl_pkg.sv
// shared constants and types of the sliding window per-key limiter
// no dependencies
`timescale 1ns / 1ps

package swpkl_pkg;

    localparam int NUM_KEYS   = 1024;
    localparam int MAX_WINDOW = 1024;

    localparam int KEY_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int KADDR_W   = $clog2(NUM_KEYS);
    localparam int SLOT_W    = $clog2(MAX_WINDOW);
    localparam int ENTRY_W   = KEY_W + 1;

    localparam logic [CNT_W-1:0]     COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;
    localparam logic [CFG_W-1:0]     WIN_MAX   = CFG_W'(MAX_WINDOW);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT    = CFG_IDX_W'(1);

    typedef struct packed {
        logic             admit;
        logic [KEY_W-1:0] key;
    } ring_entry_t;

    typedef struct packed {
        logic               discarded;
        logic [TOTAL_W-1:0] discard_total;
    } result_t;

endpackage

// File: rtl/core/swpkl_if.sv
// item and result channel interfaces with valid/ready handshake
// depends on swpkl_pkg
`timescale 1ns / 1ps

interface swpkl_item_if;
    logic                       valid;
    logic                       ready;
    logic [swpkl_pkg::KEY_W-1:0] item_key;

    modport source (output valid, output item_key, input ready);
    modport sink   (input valid, input item_key, output ready);
endinterface

interface swpkl_result_if;
    logic                         valid;
    logic                         ready;
    logic                         discarded;
    logic [swpkl_pkg::TOTAL_W-1:0] discard_total;

    modport source (output valid, output discarded, output discard_total, input ready);
    modport sink   (input valid, input discarded, input discard_total, output ready);
endinterface

// File: rtl/core/swpkl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read of the address being written returns old data
`timescale 1ns / 1ps

module swpkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/sliding_window_per_key_limiter.sv
// per-key sliding window limiter: result is valid once its item has passed the second stage
// and been pushed into the result buffer; no new item is taken while one is in the second stage,
// since the single read port of the count memory serves a read-modify-write for the arriving and
// departing key; after reset the count memory is cleared address by address; no item transfer
// meanwhile, configuration writes are taken; depends on swpkl_pkg, swpkl_if, swpkl_ram
`timescale 1ns / 1ps
`include "sliding_window_per_key_limiter_assert.svh"

module sliding_window_per_key_limiter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swpkl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swpkl_pkg::CFG_W-1:0]         cfg_data,
    swpkl_item_if.sink                          items,
    swpkl_result_if.source                      results
);

    logic [swpkl_pkg::CFG_W-1:0]   window_length_reg;
    logic [swpkl_pkg::CFG_W-1:0]   keep_limit_reg;

    logic                          clear_reg;
    logic [swpkl_pkg::KADDR_W-1:0] clr_addr_reg;

    logic [swpkl_pkg::SLOT_W-1:0]  slot_reg;
    logic [swpkl_pkg::SLOT_W-1:0]  slot_next;
    logic [swpkl_pkg::SLOT_W-1:0]  slot_eff;
    logic [swpkl_pkg::CFG_W-1:0]   slot_inc;
    logic [swpkl_pkg::CFG_W-1:0]   pos_reg;
    logic [swpkl_pkg::CFG_W-1:0]   pos_next;
    logic [swpkl_pkg::CFG_W-1:0]   w_eff;
    logic                          accept;

    logic                          s2_valid_reg;
    logic [swpkl_pkg::KEY_W-1:0]   s2_key_reg;
    logic [swpkl_pkg::SLOT_W-1:0]  s2_slot_reg;
    logic                          s2_elig_reg;
    logic                          s2_self_reg;

    logic                          s3_valid_reg;
    logic [swpkl_pkg::KEY_W-1:0]   s3_key_reg;

    logic                          cnt_we;
    logic [swpkl_pkg::KADDR_W-1:0] cnt_waddr;
    logic [swpkl_pkg::CNT_W-1:0]   cnt_wdata;
    logic [swpkl_pkg::KADDR_W-1:0] cnt_raddr;
    logic [swpkl_pkg::CNT_W-1:0]   cnt_rdata;
    logic                          fwd_hit_reg;
    logic [swpkl_pkg::CNT_W-1:0]   fwd_data_reg;
    logic [swpkl_pkg::CNT_W-1:0]   cnt_val;
    logic [swpkl_pkg::CNT_W-1:0]   cnt_inc;

    logic [swpkl_pkg::ENTRY_W-1:0] ring_rdata;
    swpkl_pkg::ring_entry_t        own_entry;
    swpkl_pkg::ring_entry_t        dep_entry;
    logic                          disc;
    logic                          dep_valid;

    logic [swpkl_pkg::TOTAL_W-1:0] discard_cnt_reg;
    logic [swpkl_pkg::TOTAL_W-1:0] discard_cnt_next;

    swpkl_pkg::result_t            ofifo_reg [2];
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    out_count_reg;
    logic                          push;
    logic                          pop;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= swpkl_pkg::CFG_W'(1);
            keep_limit_reg    <= swpkl_pkg::CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                swpkl_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                swpkl_pkg::REG_KEEP_LIMIT:    keep_limit_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // count memory clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == swpkl_pkg::KADDR_W'(swpkl_pkg::NUM_KEYS - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // first stage: slot, position and memory reads
    assign items.ready = !clear_reg && !s2_valid_reg && (out_count_reg != 2'd2);
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        if (window_length_reg == '0)
        begin
            w_eff = swpkl_pkg::CFG_W'(1);
        end
        else if (window_length_reg > swpkl_pkg::WIN_MAX)
        begin
            w_eff = swpkl_pkg::WIN_MAX;
        end
        else
        begin
            w_eff = window_length_reg;
        end
    end

    assign slot_eff  = (swpkl_pkg::CFG_W'(slot_reg) >= w_eff) ? '0 : slot_reg;
    assign slot_inc  = swpkl_pkg::CFG_W'(slot_eff) + 1'b1;
    assign slot_next = (slot_inc >= w_eff) ? '0 : slot_inc[swpkl_pkg::SLOT_W-1:0];
    assign pos_next  = (pos_reg == swpkl_pkg::WIN_MAX) ? pos_reg : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            pos_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= accept;
            if (accept)
            begin
                slot_reg <= slot_next;
                pos_reg  <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_key_reg  <= items.item_key;
            s2_slot_reg <= slot_eff;
            s2_elig_reg <= (pos_next >= w_eff);
            s2_self_reg <= (slot_next == slot_eff);
        end
    end

    // memories
    swpkl_ram #(
        .WIDTH (swpkl_pkg::CNT_W),
        .DEPTH (swpkl_pkg::NUM_KEYS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    swpkl_ram #(
        .WIDTH (swpkl_pkg::ENTRY_W),
        .DEPTH (swpkl_pkg::MAX_WINDOW)
    ) u_ring_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_slot_reg),
        .wdata (own_entry),
        .raddr (slot_next),
        .rdata (ring_rdata)
    );

    // second stage: admit decision, ring write, departing entry
    assign cnt_val = fwd_hit_reg ? fwd_data_reg : cnt_rdata;
    assign disc    = (cnt_val >= keep_limit_reg);
    assign cnt_inc = (cnt_val == swpkl_pkg::COUNT_MAX) ? cnt_val : cnt_val + 1'b1;

    assign own_entry.admit = !disc;
    assign own_entry.key   = s2_key_reg;
    assign dep_entry       = s2_self_reg ? own_entry : swpkl_pkg::ring_entry_t'(ring_rdata);
    assign dep_valid       = s2_elig_reg && dep_entry.admit;

    assign cnt_raddr = s2_valid_reg ? dep_entry.key : items.item_key;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = s2_key_reg;
        cnt_wdata = cnt_inc;
        if (clear_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_reg;
            cnt_wdata = '0;
        end
        else if (s2_valid_reg)
        begin
            cnt_we = !disc;
        end
        else if (s3_valid_reg)
        begin
            cnt_we    = (cnt_val != '0);
            cnt_waddr = s3_key_reg;
            cnt_wdata = cnt_val - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg  <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg  <= cnt_we && (cnt_waddr == cnt_raddr);
            s3_valid_reg <= s2_valid_reg && dep_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= cnt_wdata;
        if (s2_valid_reg)
        begin
            s3_key_reg <= dep_entry.key;
        end
    end

    // discard total
    always_comb
    begin
        discard_cnt_next = discard_cnt_reg;
        if (disc && (discard_cnt_reg != swpkl_pkg::TOTAL_MAX))
        begin
            discard_cnt_next = discard_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_cnt_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            discard_cnt_reg <= discard_cnt_next;
        end
    end

    // two-entry result buffer
    assign push = s2_valid_reg;
    assign pop  = results.valid && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            out_count_reg <= out_count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ofifo_reg[wr_ptr_reg].discarded     <= disc;
            ofifo_reg[wr_ptr_reg].discard_total <= discard_cnt_next;
        end
    end

    assign results.valid         = (out_count_reg != '0);
    assign results.discarded     = ofifo_reg[rd_ptr_reg].discarded;
    assign results.discard_total = ofifo_reg[rd_ptr_reg].discard_total;

    // checks
    `SWPKL_ASSERT_NEXT(a_no_back_to_back_stage2, clk, rst_n, s2_valid_reg, !s2_valid_reg)
    `SWPKL_ASSERT_NOW(a_buffer_bound, clk, rst_n, 1'b1, out_count_reg != 2'd3)
    `SWPKL_ASSERT_NEXT(a_total_monotonic, clk, rst_n, 1'b1,
        discard_cnt_reg >= $past(discard_cnt_reg))
    `SWPKL_ASSERT_NOW(a_clear_full_sweep, clk, rst_n, $fell(clear_reg),
        $past(clr_addr_reg) == swpkl_pkg::KADDR_W'(swpkl_pkg::NUM_KEYS - 1))

endmodule

// File: tb/sv/tb_sliding_window_per_key_limiter.sv
// self-checking testbench for the sliding window per-key limiter
// drives keys and settings, predicts every verdict and checks each result transfer
// depends on swpkl_pkg, swpkl_if and the limiter rtl
`timescale 1ns / 1ps

module tb_sliding_window_per_key_limiter;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [swpkl_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [swpkl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [swpkl_pkg::CFG_W-1:0]     cfg_data;

    swpkl_item_if   item_ch ();
    swpkl_result_if result_ch ();

    sliding_window_per_key_limiter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_ch),
        .results   (result_ch)
    );

    // limiter state as predicted
    logic [swpkl_pkg::CFG_W-1:0]   window_setting;
    logic [swpkl_pkg::CFG_W-1:0]   limit_setting;
    logic [swpkl_pkg::CNT_W-1:0]   admitted_count [swpkl_pkg::NUM_KEYS];
    swpkl_pkg::ring_entry_t        arrival_log [swpkl_pkg::MAX_WINDOW];
    logic [swpkl_pkg::TOTAL_W-1:0] arrivals_seen;
    int unsigned                   log_slot;
    logic [swpkl_pkg::TOTAL_W-1:0] discard_tally;

    swpkl_pkg::result_t pending_verdicts[$];

    int  fail_count;
    int  items_sent;
    int  results_seen;
    int  discards_seen;
    int  settings_written;
    int  cycle_count;
    int  hold_left;
    bit  feed_gaps_on;
    bit  drain_stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [swpkl_pkg::KEY_W-1:0] random_key(input int pool);
        if ($urandom_range(0, 7) == 0)
            return swpkl_pkg::KEY_W'($urandom_range(0, swpkl_pkg::NUM_KEYS - 1));
        return swpkl_pkg::KEY_W'($urandom_range(0, pool - 1));
    endfunction

    function automatic void clear_limiter_state();
        window_setting = swpkl_pkg::CFG_W'(1);
        limit_setting  = swpkl_pkg::CFG_W'(1);
        for (int i = 0; i < swpkl_pkg::NUM_KEYS; i++)
            admitted_count[i] = '0;
        for (int i = 0; i < swpkl_pkg::MAX_WINDOW; i++)
            arrival_log[i] = '0;
        arrivals_seen = '0;
        log_slot      = 0;
        discard_tally = '0;
    endfunction

    function automatic swpkl_pkg::result_t predict_verdict(
        input logic [swpkl_pkg::KEY_W-1:0] arriving
    );
        int unsigned            span;
        int unsigned            next_slot;
        swpkl_pkg::ring_entry_t leaving;
        swpkl_pkg::result_t     verdict;
        span = (window_setting == '0) ? 1 : int'(window_setting);
        if (span > swpkl_pkg::MAX_WINDOW)
            span = swpkl_pkg::MAX_WINDOW;
        if (log_slot >= span)
            log_slot = 0;
        if (admitted_count[arriving] >= limit_setting)
        begin
            verdict.discarded = 1'b1;
            if (discard_tally != swpkl_pkg::TOTAL_MAX)
                discard_tally++;
            arrival_log[log_slot].admit = 1'b0;
        end
        else
        begin
            verdict.discarded = 1'b0;
            if (admitted_count[arriving] != swpkl_pkg::COUNT_MAX)
                admitted_count[arriving]++;
            arrival_log[log_slot].admit = 1'b1;
        end
        arrival_log[log_slot].key = arriving;
        if (arrivals_seen != swpkl_pkg::TOTAL_MAX)
            arrivals_seen++;
        next_slot = log_slot + 1;
        if (next_slot >= span)
            next_slot = 0;
        if (arrivals_seen >= span)
        begin
            leaving = arrival_log[next_slot];
            if (leaving.admit && admitted_count[leaving.key] != '0)
                admitted_count[leaving.key]--;
        end
        log_slot = next_slot;
        verdict.discard_total = discard_tally;
        return verdict;
    endfunction

    // item transfers feed the prediction, result transfers are checked against it
    always @(posedge clk)
    begin
        swpkl_pkg::result_t want;
        if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
        begin
            pending_verdicts.push_back(predict_verdict(item_ch.item_key));
            items_sent++;
        end
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            results_seen++;
            if (result_ch.discarded === 1'b1)
                discards_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual discarded %0b total %0d",
                         $time, result_ch.discarded, result_ch.discard_total);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_ch.discarded !== want.discarded)
                begin
                    $display("%0t discarded mismatch: expected %0b actual %0b",
                             $time, want.discarded, result_ch.discarded);
                    fail_count++;
                end
                if (result_ch.discard_total !== want.discard_total)
                begin
                    $display("%0t discard_total mismatch: expected %0d actual %0d",
                             $time, want.discard_total, result_ch.discard_total);
                    fail_count++;
                end
            end
        end
    end

    // result side ready, with random stalls and the long hold-off
    initial
    begin
        int gap_left;
        gap_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                result_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (drain_stalls_on && $urandom_range(0, 4) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_key(input logic [swpkl_pkg::KEY_W-1:0] arriving);
        int gap;
        if (feed_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.item_key <= arriving;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_setting(
        input logic [swpkl_pkg::CFG_IDX_W-1:0] index,
        input logic [swpkl_pkg::CFG_W-1:0]     value
    );
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index == swpkl_pkg::REG_WINDOW_LENGTH)
            window_setting = value;
        else if (index == swpkl_pkg::REG_KEEP_LIMIT)
            limit_setting = value;
        settings_written++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(
        input logic [swpkl_pkg::CFG_W-1:0] window,
        input logic [swpkl_pkg::CFG_W-1:0] limit
    );
        wait_drained();
        write_setting(swpkl_pkg::REG_WINDOW_LENGTH, window);
        write_setting(swpkl_pkg::REG_KEEP_LIMIT, limit);
    endtask

    // window set above the maximum from the start, so the limiter clamps it to the maximum
    task automatic test_limit_cases();
        apply_settings(CFG_ALL_ONES, swpkl_pkg::CFG_W'(1));
        send_key(swpkl_pkg::KEY_W'(0));
        send_key(swpkl_pkg::KEY_W'(0));
        send_key(swpkl_pkg::KEY_W'(swpkl_pkg::NUM_KEYS - 1));
        send_key(swpkl_pkg::KEY_W'(swpkl_pkg::NUM_KEYS - 1));
        send_key(swpkl_pkg::KEY_W'(10'h155));
        send_key(swpkl_pkg::KEY_W'(10'h2AA));
        // limit of zero discards everything
        apply_settings(CFG_ALL_ONES, swpkl_pkg::CFG_W'(0));
        send_key(swpkl_pkg::KEY_W'(5));
        send_key(swpkl_pkg::KEY_W'(swpkl_pkg::NUM_KEYS - 1));
        apply_settings(CFG_ALL_ONES, CFG_ALL_ONES);
        send_key(swpkl_pkg::KEY_W'(0));
        send_key(swpkl_pkg::KEY_W'(0));
        // limit lowered below the running count
        apply_settings(CFG_ALL_ONES, swpkl_pkg::CFG_W'(1));
        send_key(swpkl_pkg::KEY_W'(0));
        send_key(swpkl_pkg::KEY_W'(3));
    endtask

    task automatic test_full_window();
        feed_gaps_on    = 1'b1;
        drain_stalls_on = 1'b1;
        apply_settings(swpkl_pkg::CFG_W'(swpkl_pkg::MAX_WINDOW), swpkl_pkg::CFG_W'(4));
        while (items_sent < swpkl_pkg::MAX_WINDOW + 32)
            send_key(random_key(16));
    endtask

    task automatic test_window_cases();
        apply_settings(swpkl_pkg::CFG_W'(0), swpkl_pkg::CFG_W'(1));
        send_key(swpkl_pkg::KEY_W'(700));
        send_key(swpkl_pkg::KEY_W'(700));
        send_key(swpkl_pkg::KEY_W'(700));
        apply_settings(swpkl_pkg::CFG_W'(5), swpkl_pkg::CFG_W'(1));
        for (int i = 0; i < 4; i++)
            send_key(swpkl_pkg::KEY_W'(701));
        // shrink so the slot pointer restarts
        apply_settings(swpkl_pkg::CFG_W'(3), swpkl_pkg::CFG_W'(1));
        send_key(swpkl_pkg::KEY_W'(701));
        send_key(swpkl_pkg::KEY_W'(702));
    endtask

    task automatic test_random_settings();
        logic [swpkl_pkg::CFG_W-1:0] window;
        logic [swpkl_pkg::CFG_W-1:0] limit;
        int                          pool;
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 4))
                0: window = swpkl_pkg::CFG_W'(1);
                1: window = swpkl_pkg::CFG_W'(swpkl_pkg::MAX_WINDOW);
                2: window = CFG_ALL_ONES;
                3: window = swpkl_pkg::CFG_W'($urandom_range(2, 16));
                default: window = swpkl_pkg::CFG_W'($urandom_range(1, swpkl_pkg::MAX_WINDOW));
            endcase
            case ($urandom_range(0, 5))
                0: limit = swpkl_pkg::CFG_W'(0);
                1: limit = CFG_ALL_ONES;
                2: limit = swpkl_pkg::CFG_W'(swpkl_pkg::MAX_WINDOW);
                default: limit = swpkl_pkg::CFG_W'($urandom_range(1, 6));
            endcase
            pool = $urandom_range(2, 64);
            apply_settings(window, limit);
            feed_gaps_on    = (phase % 3 != 2);
            drain_stalls_on = (phase % 3 != 2);
            repeat (40) send_key(random_key(pool));
        end
        feed_gaps_on    = 1'b1;
        drain_stalls_on = 1'b1;
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_result_hold();
        apply_settings(swpkl_pkg::CFG_W'(8), swpkl_pkg::CFG_W'(2));
        hold_left = HOLD_CYCLES;
        repeat (60) send_key(random_key(6));
    endtask

    // sender waits for every result before each burst
    task automatic test_sender_pause();
        apply_settings(swpkl_pkg::CFG_W'(12), swpkl_pkg::CFG_W'(3));
        for (int burst = 0; burst < 3; burst++)
        begin
            repeat (20) send_key(random_key(8));
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        item_ch.valid    = 1'b0;
        item_ch.item_key = '0;
        fail_count       = 0;
        items_sent       = 0;
        results_seen     = 0;
        discards_seen    = 0;
        settings_written = 0;
        cycle_count      = 0;
        hold_left        = 0;
        feed_gaps_on     = 1'b0;
        drain_stalls_on  = 1'b0;
        clear_limiter_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_limit_cases();
        test_full_window();
        test_window_cases();
        test_random_settings();
        test_result_hold();
        test_sender_pause();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d keys, %0d verdicts (%0d discards), %0d register writes",
                 items_sent, results_seen, discards_seen, settings_written);
        $display("windows from one up to beyond the maximum, limits from zero to all ones");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/swpkl_pkg.sv
rtl/core/swpkl_if.sv
rtl/core/swpkl_ram.sv
rtl/core/sliding_window_per_key_limiter.sv
tb/sv/tb_sliding_window_per_key_limiter.sv
